// ===== rtl/core/wlc_pkg.sv =====
// ----------------------------------------------------------------------------
// wlc_pkg
// Shared types and constants for the word lexer / classifier.
// ----------------------------------------------------------------------------
package wlc_pkg;

  localparam int MaxWordLenDef = 255;

  // token queue between front and back
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QLevelW = $clog2(QDepth + 1);

  // token classes
  localparam logic [3:0] ClEquals  = 4'd0;
  localparam logic [3:0] ClBrkOpen = 4'd1;
  localparam logic [3:0] ClBrkClos = 4'd2;
  localparam logic [3:0] ClBrcOpen = 4'd3;
  localparam logic [3:0] ClBrcClos = 4'd4;
  localparam logic [3:0] ClSemi    = 4'd5;
  localparam logic [3:0] ClOper    = 4'd6;
  localparam logic [3:0] ClIdent   = 4'd7;
  localparam logic [3:0] ClLong    = 4'd8;
  localparam logic [3:0] ClFloat   = 4'd9;
  localparam logic [3:0] ClInt     = 4'd10;
  localparam logic [3:0] ClInvalid = 4'd11;

  typedef struct packed {
    logic [3:0] cls;
    logic [7:0] len;
    logic       last;
  } token_t;

  // up to two tokens pushed per beat; t0 always comes first
  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } push_t;

  typedef struct packed {
    logic [QLevelW-1:0] level;
    logic               empty;
    logic               room;   // space for two more tokens
  } qstat_t;

endpackage

// ===== rtl/core/wlc_front.sv =====
// ----------------------------------------------------------------------------
// wlc_front
// Accepts one character a beat, runs the word automaton and pushes tokens.
// ----------------------------------------------------------------------------
module wlc_front #(
  parameter int MAX_WORD_LEN = wlc_pkg::MaxWordLenDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_i,
  input  logic            has_char_i,
  input  logic            eol_i,
  input  wlc_pkg::qstat_t qstat_i,
  output wlc_pkg::push_t  push_o
);
  import wlc_pkg::*;

  localparam logic [7:0] LenCap = (MAX_WORD_LEN > 255) ? 8'd255 : 8'(MAX_WORD_LEN);

  // automaton states
  localparam logic [3:0] StEmpty = 4'd0;
  localparam logic [3:0] StEq    = 4'd1;
  localparam logic [3:0] StOp1   = 4'd2;
  localparam logic [3:0] StOp2   = 4'd3;
  localparam logic [3:0] StIdent = 4'd4;
  localparam logic [3:0] StInt   = 4'd5;
  localparam logic [3:0] StDot   = 4'd6;
  localparam logic [3:0] StFrac  = 4'd7;
  localparam logic [3:0] StLong  = 4'd8;
  localparam logic [3:0] StBad   = 4'd9;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_opchar(logic [7:0] c);
    return (c == 8'h2f) || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a);
  endfunction

  function automatic logic [3:0] next_state(logic [3:0] s, logic [7:0] c);
    logic [3:0] n;
    n = StBad;
    case (s)
      StEmpty: begin
        if (c == 8'h3d)        n = StEq;
        else if (is_opchar(c)) n = StOp1;
        else if (is_letter(c)) n = StIdent;
        else if (is_digit(c))  n = StInt;
      end
      StOp1:   n = (c == 8'h3d) ? StOp2 : StBad;
      StIdent: n = (is_letter(c) || is_digit(c)) ? StIdent : StBad;
      StInt: begin
        if (is_digit(c))       n = StInt;
        else if (c == 8'h2e)   n = StDot;
      end
      StDot:   n = is_digit(c) ? StFrac : StBad;
      StFrac: begin
        if (is_digit(c))       n = StFrac;
        else if (c == 8'h4c)   n = StLong;
      end
      default: n = StBad;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] final_class(logic [3:0] s);
    logic [3:0] k;
    case (s)
      StEq:         k = ClEquals;
      StOp1, StOp2: k = ClOper;
      StIdent:      k = ClIdent;
      StInt:        k = ClInt;
      StFrac:       k = ClFloat;
      StLong:       k = ClLong;
      default:      k = ClInvalid;
    endcase
    return k;
  endfunction

  logic [3:0] state_q, state_d, st_mid;
  logic [7:0] len_q, len_d, len_mid;
  logic       is_single, is_space, normal, flush, word_v, take;
  logic [3:0] single_cls;

  assign in_ready_o = qstat_i.room;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    is_single  = 1'b1;
    single_cls = ClInvalid;
    case (char_i)
      8'h5b:   single_cls = ClBrkOpen;
      8'h5d:   single_cls = ClBrkClos;
      8'h7b:   single_cls = ClBrcOpen;
      8'h7d:   single_cls = ClBrcClos;
      8'h3b:   single_cls = ClSemi;
      8'h2c:   single_cls = ClInvalid;
      default: is_single  = 1'b0;
    endcase
  end

  assign is_space = (char_i == 8'h20);
  assign normal   = has_char_i && !is_single && !is_space;
  assign st_mid   = normal ? next_state(state_q, char_i) : state_q;
  assign len_mid  = (normal && (len_q < LenCap)) ? len_q + 8'd1 : len_q;
  assign flush    = (has_char_i && (is_single || is_space)) || eol_i;
  assign word_v   = flush && (st_mid != StEmpty);
  assign state_d  = flush ? StEmpty : st_mid;
  assign len_d    = flush ? 8'd0 : len_mid;

  always_comb begin
    push_o.v0      = take && (word_v || (has_char_i && is_single));
    push_o.v1      = take && word_v && has_char_i && is_single;
    push_o.t1.cls  = single_cls;
    push_o.t1.len  = 8'd1;
    push_o.t1.last = 1'b1;
    if (word_v) begin
      push_o.t0.cls  = final_class(st_mid);
      push_o.t0.len  = len_mid;
      push_o.t0.last = !(has_char_i && is_single);
    end else begin
      push_o.t0 = push_o.t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StEmpty;
      len_q   <= 8'd0;
    end else if (take) begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

endmodule

// ===== rtl/core/wlc_queue.sv =====
// ----------------------------------------------------------------------------
// wlc_queue
// Small token queue: two writes and one read per cycle.
// ----------------------------------------------------------------------------
module wlc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wlc_pkg::push_t  push_i,
  input  logic            pop_i,
  output wlc_pkg::token_t head_o,
  output wlc_pkg::qstat_t qstat_o
);
  import wlc_pkg::*;

  token_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q, wr_nx;
  logic [QLevelW-1:0] level_q, level_d;

  assign wr_nx   = wr_q + QPtrW'(1);
  assign head_o  = mem_q[rd_q];
  assign level_d = level_q + QLevelW'(push_i.v0) + QLevelW'(push_i.v1) - QLevelW'(pop_i);

  assign qstat_o.level = level_q;
  assign qstat_o.empty = (level_q == '0);
  assign qstat_o.room  = (level_q <= QLevelW'(QDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q]  <= push_i.t0;
    if (push_i.v1) mem_q[wr_nx] <= push_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + QPtrW'(push_i.v0) + QPtrW'(push_i.v1);
      if (pop_i) rd_q <= rd_q + QPtrW'(1);
      level_q <= level_d;
    end
  end

endmodule

// ===== rtl/core/wlc_out.sv =====
// ----------------------------------------------------------------------------
// wlc_out
// Output register: takes tokens off the queue and presents them downstream.
// ----------------------------------------------------------------------------
module wlc_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wlc_pkg::token_t head_i,
  input  wlc_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wlc_pkg::token_t out_tok_o
);
  import wlc_pkg::*;

  logic   valid_q;
  token_t tok_q;

  assign pop_o       = !qstat_i.empty && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !qstat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) tok_q <= head_i;
  end

endmodule

// ===== rtl/core/word_lexer_classifier_top.sv =====
// ----------------------------------------------------------------------------
// word_lexer_classifier_top
// Line lexer: splits characters into words and one-character tokens and
// classifies each word.
// ----------------------------------------------------------------------------
// Usage
//   Slave side: one character per beat. tdata carries the byte, tuser says
//   whether the byte is present (0 = bare end marker), tlast ends the line
//   and flushes any open word.
//   Master side: one token per beat, class and saturated length in tdata,
//   tlast set on the final token caused by a given input beat. Beats that
//   only extend a word give no token.
//   Throughput: one character per cycle while the queue has room. A beat
//   that emits two tokens (word ended by a bracket, brace, semicolon or
//   comma) pushes both at once into the four-entry queue, so the sustained
//   rate is one input beat per cycle while tokens average at most one per beat.
//   Path: a token is written into the queue, then loaded into the output
//   register before it appears on the master side.
//   Reset: asynchronous, clears the automaton, queue pointers and level, and output valid.
//   Downstream stall: the output register holds; the queue fills and
//   s_axis_tready drops once fewer than two slots are free. tready depends
//   only on registered queue level, never on m_axis_tready.
// ----------------------------------------------------------------------------
module word_lexer_classifier_top #(
  parameter int MAX_WORD_LEN = wlc_pkg::MaxWordLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,   // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] token_class, [11:4] token_length, rest 0
  output logic        m_axis_tlast    // last_of_run
);
  import wlc_pkg::*;

  push_t  push;
  qstat_t qstat;
  token_t head, out_tok;
  logic   pop;

  // front: automaton and token generation
  wlc_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .has_char_i (s_axis_tuser),
    .eol_i      (s_axis_tlast),
    .qstat_i    (qstat),
    .push_o     (push)
  );

  // decoupling queue
  wlc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // back: output register
  wlc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok)
  );

  assign m_axis_tdata = {4'd0, out_tok.len, out_tok.cls};
  assign m_axis_tlast = out_tok.last;

  // queue never overfills
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.level <= QLevelW'(QDepth))
    else $error("token queue overflow");

  // a second token only ever follows a first one
  a_push_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> push.v0)
    else $error("second token pushed without first");

  // a beat with neither a character nor end of line produces nothing
  a_idle_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast) |-> !push.v0)
    else $error("token from empty beat");

  // nothing is popped from an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
